/* rtl/efcp_pkg.sv */
// Shared types, constants and the sine table generator for the fly camera pose block.
// No dependencies; used by efcp_mul, efcp_sine_rom and euler_fly_camera_pose.
`timescale 1ns / 1ps

package efcp_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int ANGLE_FRAC_BITS  = 8;
   localparam int IDX_BITS         = $clog2(SINE_TABLE_DEPTH);

   localparam int FULL_TURN    = 360 << ANGLE_FRAC_BITS;
   localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
   localparam int ANGLE_BITS   = $clog2(FULL_TURN);

   // Table index of angle a is floor((a + ANGLE_STEP/2) / ANGLE_STEP).
   localparam int ANGLE_STEP   = FULL_TURN / SINE_TABLE_DEPTH;
   localparam int ANGLE_HALF   = ANGLE_STEP / 2;
   localparam int RECIP_SHIFT  = 24;
   localparam int RECIP        = ((1 << RECIP_SHIFT) + ANGLE_STEP - 1) / ANGLE_STEP;
   localparam int QUARTER_IDX  = SINE_TABLE_DEPTH / 4;

   localparam int MUL_BITS  = 19;
   localparam int PROD_BITS = 2 * MUL_BITS;

   localparam int ONE_Q14 = 16384;

   localparam logic [63:0] PI_Q28      = 64'd843314857;
   localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;
   localparam logic [63:0] TWO_PI_Q28  = 64'd1686629713;

   typedef enum logic [2:0] {
      CMD_FORWARD = 3'd0,
      CMD_BACK    = 3'd1,
      CMD_LEFT    = 3'd2,
      CMD_RIGHT   = 3'd3,
      CMD_ROTATE  = 3'd4
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_MOVE_STEP   = 1'b0,
      CSR_PITCH_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [15:0] yaw_delta;
      logic signed [15:0] pitch_delta;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] front_x;
      logic signed [15:0] front_y;
      logic signed [15:0] front_z;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
   } rsp_type;

   typedef logic signed [15:0] sine_table_type [SINE_TABLE_DEPTH];

   // Sine of an angle in the first quadrant (Q28 radians) by a Taylor series, Q2.14.
   function automatic logic [15:0] sine_first_quadrant(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        r;
      x2   = (x * x) >> 28;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 28) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = ($unsigned(sum) + 64'd8192) >> 14;
      if (r > 64'(ONE_Q14)) begin
         r = 64'(ONE_Q14);
      end
      return r[15:0];
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type tab;
      logic [63:0]    x;
      logic           neg;
      logic [15:0]    s;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         x   = (64'(k) * TWO_PI_Q28 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
         neg = 1'b0;
         if (x >= PI_Q28) begin
            x   = x - PI_Q28;
            neg = 1'b1;
         end
         if (x > HALF_PI_Q28) begin
            x = PI_Q28 - x;
         end
         s      = sine_first_quadrant(x);
         tab[k] = neg ? -$signed(s) : $signed(s);
      end
      return tab;
   endfunction

   // Q14 product shifted right by 14, rounded half away from zero.
   function automatic logic signed [17:0] round_q14(input logic signed [PROD_BITS-1:0] p);
      logic [PROD_BITS-1:0] mag;
      logic [PROD_BITS-1:0] m;
      logic signed [17:0]   r;
      mag = p[PROD_BITS-1] ? $unsigned(-p) : $unsigned(p);
      m   = (mag + PROD_BITS'(8192)) >> 14;
      r   = $signed(m[17:0]);
      return p[PROD_BITS-1] ? -r : r;
   endfunction

endpackage

/* rtl/efcp_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on efcp_pkg for operand and product widths.
`timescale 1ns / 1ps

module efcp_mul (
   input  logic                                  clock,
   input  logic signed [efcp_pkg::MUL_BITS-1:0]  op_a,
   input  logic signed [efcp_pkg::MUL_BITS-1:0]  op_b,
   output logic signed [efcp_pkg::PROD_BITS-1:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule

/* rtl/efcp_sine_rom.sv */
// Sine lookup over one full turn in Q2.14, registered read.
// Depends on efcp_pkg for the table contents and index width.
`timescale 1ns / 1ps

module efcp_sine_rom (
   input  logic                                clock,
   input  logic [efcp_pkg::IDX_BITS-1:0]       addr,
   output logic signed [15:0]                  data_ff
);

   localparam efcp_pkg::sine_table_type SINE_TABLE = efcp_pkg::build_sine_table();

   always_ff @(posedge clock) begin
      data_ff <= SINE_TABLE[addr];
   end

endmodule

/* rtl/euler_fly_camera_pose.sv */
// Top level of the fly camera pose block: sequencer, pose state and result register.
// Depends on efcp_pkg, efcp_mul and efcp_sine_rom.
`timescale 1ns / 1ps

// The block keeps a camera pose (yaw, pitch, position and the front, right and up
// vectors) and updates it once per request transaction on the req_ channel.
// Each transaction returns exactly one response transaction on the rsp_ channel
// carrying the new position and basis.
// A move command updates the three axes in turn: for each axis the shared multiplier
// forms one step component and a saturating add applies it to the position.
// For a rotate command, two multiplier passes turn the angles into table indices,
// four reads of the sine ROM follow, then four multiplier passes build the basis
// products. Unused command codes go straight to the response, pose unchanged.
// req_ready is high only while the sequencer is idle; one item is worked on at a time,
// so a new request is not taken until the last response is in the output register.
// The response is held in an output register, so the next request can be taken
// while a finished response still waits. If the receiver stalls, a second finished
// response waits in the last sequencer step until the output register frees up.
// Synchronous reset restores the default pose (yaw 270 degrees, pitch 0, position
// 0, 2, 6) and the default registers; no response is pending after reset.
// The csr_ port writes move_step or pitch_limit; write only when idle.
module euler_fly_camera_pose (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  efcp_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output efcp_pkg::rsp_type     rsp_data,
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [16:0]           csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOVE_MUL,
      ST_MOVE_ADD,
      ST_YIDX,
      ST_PIDX,
      ST_RSY,
      ST_RCY,
      ST_RSP,
      ST_RCP,
      ST_M0,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_OUT
   } state_type;

   localparam int IB = efcp_pkg::IDX_BITS;
   localparam int AB = efcp_pkg::ANGLE_BITS;
   localparam int MB = efcp_pkg::MUL_BITS;
   localparam int PB = efcp_pkg::PROD_BITS;

   state_type                state_ff;
   logic [16:0]              move_step_ff;
   logic [14:0]              pitch_limit_ff;
   logic [AB-1:0]            yaw_ff;
   logic signed [15:0]       pitch_ff;
   logic signed [31:0]       pos_ff [3];
   logic signed [15:0]       basis_ff [9];
   logic [1:0]               cnt_ff;
   logic [3:0]               dir_base_ff;
   logic                     negate_ff;
   logic [IB-1:0]            yidx_ff;
   logic [IB-1:0]            pidx_ff;
   logic signed [15:0]       sy_ff;
   logic signed [15:0]       cy_ff;
   logic signed [15:0]       sp_ff;
   logic signed [15:0]       cp_ff;
   logic                     rsp_valid_ff;
   efcp_pkg::rsp_type        rsp_data_ff;

   logic signed [MB-1:0]     mul_a;
   logic signed [MB-1:0]     mul_b;
   logic signed [PB-1:0]     prod_ff;
   logic [IB-1:0]            rom_addr;
   logic signed [15:0]       rom_data_ff;

   logic signed [17:0]       yaw_sum;
   logic [AB-1:0]            yaw_wrap;
   logic [14:0]              lim;
   logic signed [17:0]       pitch_diff;
   logic signed [15:0]       pitch_clamp;
   logic [AB-1:0]            pitch_pos;
   logic [3:0]               dir_idx;
   logic signed [17:0]       step;
   logic signed [33:0]       pos_sum;
   logic signed [31:0]       pos_sat;
   logic signed [17:0]       prod_rnd;
   logic [IB-1:0]            prod_idx;

   efcp_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   efcp_sine_rom u_rom (
      .clock   (clock),
      .addr    (rom_addr),
      .data_ff (rom_data_ff)
   );

   // Angle update for a rotate: yaw wraps by one turn either way, pitch clamps.
   always_comb begin
      yaw_sum = $signed({1'b0, yaw_ff}) + 18'(req_data.yaw_delta);
      if (yaw_sum < 0) begin
         yaw_wrap = AB'(yaw_sum + 18'(efcp_pkg::FULL_TURN));
      end else if (yaw_sum >= 18'(efcp_pkg::FULL_TURN)) begin
         yaw_wrap = AB'(yaw_sum - 18'(efcp_pkg::FULL_TURN));
      end else begin
         yaw_wrap = AB'(yaw_sum);
      end
      lim = (pitch_limit_ff > 15'(efcp_pkg::QUARTER_TURN)) ?
            15'(efcp_pkg::QUARTER_TURN) : pitch_limit_ff;
      pitch_diff = 18'(pitch_ff) - 18'(req_data.pitch_delta);
      if (pitch_diff > $signed({3'b000, lim})) begin
         pitch_clamp = $signed({1'b0, lim});
      end else if (pitch_diff < -$signed({3'b000, lim})) begin
         pitch_clamp = -$signed({1'b0, lim});
      end else begin
         pitch_clamp = pitch_diff[15:0];
      end
      pitch_pos = pitch_ff[15] ? AB'(18'(pitch_ff) + 18'(efcp_pkg::FULL_TURN))
                               : AB'(pitch_ff);
   end

   // Move arithmetic: rounded step, signed add with saturation to 32 bits.
   always_comb begin
      dir_idx  = dir_base_ff + {2'b00, cnt_ff};
      prod_rnd = efcp_pkg::round_q14(prod_ff);
      prod_idx = prod_ff[efcp_pkg::RECIP_SHIFT +: IB];
      step     = negate_ff ? -prod_rnd : prod_rnd;
      pos_sum  = 34'(pos_ff[cnt_ff]) + 34'(step);
      if (pos_sum > 34'sh0_7FFF_FFFF) begin
         pos_sat = 32'sh7FFF_FFFF;
      end else if (pos_sum < -34'sh0_8000_0000) begin
         pos_sat = -32'sh8000_0000;
      end else begin
         pos_sat = pos_sum[31:0];
      end
   end

   // Operand selection for the shared multiplier and the ROM address.
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      rom_addr = yidx_ff;
      case (state_ff)
         ST_MOVE_MUL: begin
            mul_a = MB'(basis_ff[dir_idx]);
            mul_b = $signed({2'b00, move_step_ff});
         end
         ST_YIDX: begin
            mul_a = $signed(MB'(yaw_ff) + MB'(efcp_pkg::ANGLE_HALF));
            mul_b = MB'(efcp_pkg::RECIP);
         end
         ST_PIDX: begin
            mul_a = $signed(MB'(pitch_pos) + MB'(efcp_pkg::ANGLE_HALF));
            mul_b = MB'(efcp_pkg::RECIP);
         end
         ST_RSY:  rom_addr = yidx_ff;
         ST_RCY:  rom_addr = yidx_ff + IB'(efcp_pkg::QUARTER_IDX);
         ST_RSP:  rom_addr = pidx_ff;
         ST_RCP:  rom_addr = pidx_ff + IB'(efcp_pkg::QUARTER_IDX);
         ST_M0: begin
            mul_a = MB'(cy_ff);
            mul_b = MB'(rom_data_ff);
         end
         ST_M1: begin
            mul_a = MB'(sy_ff);
            mul_b = MB'(cp_ff);
         end
         ST_M2: begin
            mul_a = MB'(cy_ff);
            mul_b = MB'(sp_ff);
         end
         ST_M3: begin
            mul_a = MB'(sy_ff);
            mul_b = MB'(sp_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         move_step_ff   <= 17'd6554;
         pitch_limit_ff <= 15'd22784;
         yaw_ff         <= AB'(270 << efcp_pkg::ANGLE_FRAC_BITS);
         pitch_ff       <= '0;
         pos_ff[0]      <= 32'sd0;
         pos_ff[1]      <= 32'sd131072;
         pos_ff[2]      <= 32'sd393216;
         for (int i = 0; i < 9; i++) begin
            basis_ff[i] <= '0;
         end
         basis_ff[2]    <= -16'(efcp_pkg::ONE_Q14);
         basis_ff[3]    <= 16'(efcp_pkg::ONE_Q14);
         basis_ff[7]    <= 16'(efcp_pkg::ONE_Q14);
         cnt_ff         <= '0;
         dir_base_ff    <= '0;
         negate_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               efcp_pkg::CSR_MOVE_STEP:   move_step_ff   <= csr_data;
               efcp_pkg::CSR_PITCH_LIMIT: pitch_limit_ff <= csr_data[14:0];
               default:                   move_step_ff   <= move_step_ff;
            endcase
         end

         // The output step reloads the register itself when it frees up.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cnt_ff <= '0;
                  case (req_data.cmd)
                     efcp_pkg::CMD_FORWARD: begin
                        dir_base_ff <= 4'd0;
                        negate_ff   <= 1'b0;
                        state_ff    <= ST_MOVE_MUL;
                     end
                     efcp_pkg::CMD_BACK: begin
                        dir_base_ff <= 4'd0;
                        negate_ff   <= 1'b1;
                        state_ff    <= ST_MOVE_MUL;
                     end
                     efcp_pkg::CMD_LEFT: begin
                        dir_base_ff <= 4'd3;
                        negate_ff   <= 1'b1;
                        state_ff    <= ST_MOVE_MUL;
                     end
                     efcp_pkg::CMD_RIGHT: begin
                        dir_base_ff <= 4'd3;
                        negate_ff   <= 1'b0;
                        state_ff    <= ST_MOVE_MUL;
                     end
                     efcp_pkg::CMD_ROTATE: begin
                        yaw_ff   <= yaw_wrap;
                        pitch_ff <= pitch_clamp;
                        state_ff <= ST_YIDX;
                     end
                     default: begin
                        state_ff <= ST_OUT;
                     end
                  endcase
               end
            end
            ST_MOVE_MUL: state_ff <= ST_MOVE_ADD;
            ST_MOVE_ADD: begin
               pos_ff[cnt_ff] <= pos_sat;
               if (cnt_ff == 2'd2) begin
                  state_ff <= ST_OUT;
               end else begin
                  cnt_ff   <= cnt_ff + 2'd1;
                  state_ff <= ST_MOVE_MUL;
               end
            end
            ST_YIDX: state_ff <= ST_PIDX;
            ST_PIDX: begin
               yidx_ff  <= prod_idx;
               state_ff <= ST_RSY;
            end
            ST_RSY: begin
               pidx_ff  <= prod_idx;
               state_ff <= ST_RCY;
            end
            ST_RCY: begin
               sy_ff    <= rom_data_ff;
               state_ff <= ST_RSP;
            end
            ST_RSP: begin
               cy_ff    <= rom_data_ff;
               state_ff <= ST_RCP;
            end
            ST_RCP: begin
               sp_ff    <= rom_data_ff;
               state_ff <= ST_M0;
            end
            ST_M0: begin
               cp_ff    <= rom_data_ff;
               state_ff <= ST_M1;
            end
            ST_M1: begin
               basis_ff[0] <= prod_rnd[15:0];
               state_ff    <= ST_M2;
            end
            ST_M2: begin
               basis_ff[2] <= prod_rnd[15:0];
               state_ff    <= ST_M3;
            end
            ST_M3: begin
               basis_ff[6] <= -prod_rnd[15:0];
               state_ff    <= ST_M4;
            end
            ST_M4: begin
               basis_ff[8] <= -prod_rnd[15:0];
               basis_ff[1] <= sp_ff;
               basis_ff[3] <= -sy_ff;
               basis_ff[4] <= '0;
               basis_ff[5] <= cy_ff;
               basis_ff[7] <= cp_ff;
               state_ff    <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_data_ff.pos_x   <= pos_ff[0];
                  rsp_data_ff.pos_y   <= pos_ff[1];
                  rsp_data_ff.pos_z   <= pos_ff[2];
                  rsp_data_ff.front_x <= basis_ff[0];
                  rsp_data_ff.front_y <= basis_ff[1];
                  rsp_data_ff.front_z <= basis_ff[2];
                  rsp_data_ff.right_x <= basis_ff[3];
                  rsp_data_ff.right_y <= basis_ff[4];
                  rsp_data_ff.right_z <= basis_ff[5];
                  rsp_data_ff.up_x    <= basis_ff[6];
                  rsp_data_ff.up_y    <= basis_ff[7];
                  rsp_data_ff.up_z    <= basis_ff[8];
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Only one item is in flight: a request taken leaves the sequencer busy.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item was in flight");

   // The stored yaw always lies within one turn.
   assert property (@(posedge clock) disable iff (reset)
      yaw_ff < AB'(efcp_pkg::FULL_TURN))
      else $error("yaw left the range of one turn");

   // The stored pitch never passes a quarter turn either way.
   assert property (@(posedge clock) disable iff (reset)
      (pitch_ff <= 16'(efcp_pkg::QUARTER_TURN)) && (pitch_ff >= -16'(efcp_pkg::QUARTER_TURN)))
      else $error("pitch beyond a quarter turn");

   // The right vector stays in the horizontal plane.
   assert property (@(posedge clock) disable iff (reset)
      basis_ff[4] == 16'sd0)
      else $error("right vector has a vertical component");

endmodule
